>>> hdl/mavg_pkg.sv
// shared types and constants for the moving average block
`timescale 1ns / 1ps

package mavg_pkg;

   localparam int SAMPLE_W = 16;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV
   } state_type;

   // divider status seen by the control logic
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> hdl/mavg_cell.sv
// one sample cell of the shift chain
`timescale 1ns / 1ps

module mavg_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  mavg_pkg::sample_type d,
   output mavg_pkg::sample_type q
);

   mavg_pkg::sample_type sample_ff;
   mavg_pkg::sample_type sample_in;

   assign sample_in = shift ? d : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   assign q = sample_ff;

endmodule

>>> hdl/mavg_div.sv
// iterative signed-by-unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps

module mavg_div #(
   parameter int SUM_W = 19,
   parameter int CNT_W = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SUM_W-1:0]       dividend,
   input  logic [CNT_W-1:0]              divisor,
   output mavg_pkg::sample_type          quotient,
   output mavg_pkg::div_status_type      status
);

   localparam int REM_W  = CNT_W + 1;
   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  mag_ff,  mag_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [CNT_W-1:0]  den_ff,  den_in;
   logic              neg_ff,  neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W-1:0]  rem_shift;
   logic [REM_W:0]    diff;
   logic              fits;
   logic [SUM_W-1:0]  signed_q;

   assign rem_shift = {rem_ff[REM_W-2:0], mag_ff[SUM_W-1]};
   assign diff      = {1'b0, rem_shift} - (REM_W + 1)'(den_ff);
   assign fits      = !diff[REM_W];

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         mag_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         mag_in  = {mag_ff[SUM_W-2:0], fits};
         rem_in  = fits ? diff[REM_W-1:0] : rem_shift;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // truncation toward zero: divide magnitudes, then restore the sign
   assign signed_q    = neg_ff ? (~mag_ff + SUM_W'(1)) : mag_ff;
   assign quotient    = signed_q[mavg_pkg::SAMPLE_W-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> hdl/moving_average_warmup_top.sv
// moving average over the last WINDOW samples with warm-up divisor
`timescale 1ns / 1ps
//
// Input channel req_valid/req_ready/req_sample carries one signed 16-bit
// sample per transfer; result channel rsp_valid/rsp_ready/rsp_average
// returns one signed 16-bit average per sample, in order.
// The samples sit in a chain of WINDOW cells; each transfer shifts the new
// sample in and the oldest one out, and the running sum is updated by
// adding the new and subtracting the oldest. The average is the sum divided
// by the number of samples seen (saturating at WINDOW), truncated toward
// zero, computed by a restoring divider that makes one quotient bit per
// cycle. One sample is in flight at a time, so a new sample can be taken
// in the cycle after the previous result is loaded into the output register.
// A result waiting on a stalled receiver stays in the output register and
// the next sample may still be taken; its result waits in the divider until
// the output register is free.
// Reset clears the cells, the sum, the fill count and both channels.
//
module moving_average_warmup_top #(
   parameter int WINDOW = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [15:0]   req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_average
);

   localparam int SUM_W = mavg_pkg::SAMPLE_W + $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);

   mavg_pkg::state_type state_ff, state_in;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   mavg_pkg::sample_type    rsp_average_ff, rsp_average_in;

   mavg_pkg::sample_type    ring_q [WINDOW];
   mavg_pkg::sample_type    div_q;
   mavg_pkg::div_status_type div_stat;
   logic                    accept;
   logic                    div_start;
   logic                    rsp_load;

   assign accept = req_valid && req_ready;

   // sample chain, oldest sample in the last cell
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
         mavg_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (accept),
            .d     (req_sample),
            .q     (ring_q[i])
         );
      end else begin : g_body
         mavg_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (accept),
            .d     (ring_q[i-1]),
            .q     (ring_q[i])
         );
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         sum_in = sum_ff + SUM_W'(req_sample) - SUM_W'(ring_q[WINDOW-1]);
         if (count_ff != CNT_W'(WINDOW)) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   mavg_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .quotient (div_q),
      .status   (div_stat)
   );

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      div_start      = 1'b0;
      rsp_load       = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_average_in = rsp_average_ff;
      unique case (state_ff)
         mavg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = mavg_pkg::ST_START;
            end
         end
         mavg_pkg::ST_START: begin
            div_start = 1'b1;
            state_in  = mavg_pkg::ST_DIV;
         end
         mavg_pkg::ST_DIV: begin
            if (div_stat.done && (!rsp_valid_ff || rsp_ready)) begin
               rsp_load       = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_average_in = div_q;
               state_in       = mavg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mavg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mavg_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_average_ff <= rsp_average_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("sample taken while previous one still in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW))
      else $error("fill count beyond window");

   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_load_after_div: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (div_stat.done && !div_stat.busy))
      else $error("result loaded before division finished");

endmodule
